>>> rtl/core/vertex_transform_perspective_divide_unit_macros.svh
// Assertion macros for the vertex transform unit.
// Included by the top level; each macro expects i_clk and i_rst_n in scope.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_UNIT_MACROS_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_UNIT_MACROS_SVH

`define VTPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define VTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/vtpd_pkg.sv
// Shared constants and types for the vertex transform unit.
// No dependencies; imported by every module of the block.
package vtpd_pkg;

    localparam int NUM_ROWS    = 4;
    localparam int NUM_LANES   = 3;
    localparam int ROW_WIDTH   = 64;
    localparam int SLOT_WIDTH  = 16;
    localparam int PORT_WIDTH  = 32;
    localparam int ACC_SHIFT   = 8;
    localparam int FRAC_BITS   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef enum logic [1:0] {
        CFG_ROW0,
        CFG_ROW1,
        CFG_ROW2,
        CFG_ROW3
    } t_cfg_idx;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    function automatic logic [ROW_WIDTH-1:0] row_reset(input logic [1:0] idx);
        logic [ROW_WIDTH-1:0] one;
        one = ROW_WIDTH'(256);
        return one << (SLOT_WIDTH * idx);
    endfunction

endpackage

>>> rtl/core/vtpd_front.sv
// Front end: coefficient products and dot-product reduction.
// Depends on vtpd_pkg.
module vtpd_front
    import vtpd_pkg::*;
#(
    parameter int CW = 16,
    parameter int DW = 32,
    parameter int AW = CW + DW - 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [PORT_WIDTH-1:0]         i_x,
    input  logic [PORT_WIDTH-1:0]         i_y,
    input  logic [PORT_WIDTH-1:0]         i_z,
    input  logic [NUM_ROWS*ROW_WIDTH-1:0] i_rows,
    output logic                          o_valid,
    output logic [NUM_ROWS*AW-1:0]        o_acc
);

    localparam int PW = CW + DW;
    localparam int SW = CW + DW + 2;

    logic signed [DW-1:0] coord [NUM_LANES];
    logic signed [PW-1:0] n_prod [NUM_ROWS][NUM_LANES];
    logic signed [PW-1:0] r_prod [NUM_ROWS][NUM_LANES];
    logic signed [CW-1:0] n_wcoef [NUM_ROWS];
    logic signed [CW-1:0] r_wcoef [NUM_ROWS];
    logic signed [SW-1:0] n_sum [NUM_ROWS];
    logic [NUM_ROWS*AW-1:0] n_acc;
    logic [NUM_ROWS*AW-1:0] r_acc;
    logic r_v1;
    logic r_v2;

    assign coord[0] = $signed(i_x[DW-1:0]);
    assign coord[1] = $signed(i_y[DW-1:0]);
    assign coord[2] = $signed(i_z[DW-1:0]);

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int j = 0; j < NUM_LANES; j++) begin
                n_prod[r][j] = $signed(i_rows[r*ROW_WIDTH + j*SLOT_WIDTH +: CW]) * coord[j];
            end
            n_wcoef[r] = $signed(i_rows[r*ROW_WIDTH + NUM_LANES*SLOT_WIDTH +: CW]);
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            n_sum[r] = SW'(r_prod[r][0]) + SW'(r_prod[r][1]) + SW'(r_prod[r][2])
                     + (SW'(r_wcoef[r]) <<< FRAC_BITS);
            n_acc[r*AW +: AW] = n_sum[r][SW-1:ACC_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_wcoef <= n_wcoef;
        r_acc   <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_acc   = r_acc;

endmodule

>>> rtl/core/vtpd_queue.sv
// Short queue between the front end and the back end, with registered read.
// Depends on vtpd_pkg.
module vtpd_queue
    import vtpd_pkg::*;
#(
    parameter int WIDTH = 168
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);

    logic [WIDTH-1:0]       r_mem [QUEUE_DEPTH];
    logic [WIDTH-1:0]       r_rd_data;
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_CNT_W-1:0] n_count;
    logic                   r_valid;
    logic                   pop;

    assign pop = (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + QUEUE_CNT_W'(1);
        end else if (pop && !i_push) begin
            n_count = r_count - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            r_count <= n_count;
            r_valid <= pop;
        end
    end

    assign o_valid      = r_valid;
    assign o_data       = r_rd_data;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));

endmodule

>>> rtl/core/vtpd_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
// Depends on vtpd_pkg.
module vtpd_div
    import vtpd_pkg::*;
#(
    parameter int NW  = 58,
    parameter int DNW = 42,
    parameter int SBW = 44
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [NW-1:0]  i_num,
    input  logic [DNW-1:0] i_den,
    input  logic [SBW-1:0] i_side,
    output logic           o_valid,
    output logic [NW-1:0]  o_quo,
    output logic [SBW-1:0] o_side
);

    logic [DNW-1:0] w_rem  [NW+1];
    logic [NW-1:0]  w_n    [NW+1];
    logic [DNW-1:0] w_den  [NW+1];
    logic [SBW-1:0] w_side [NW+1];
    logic           w_v    [NW+1];

    assign w_rem[0]  = '0;
    assign w_n[0]    = i_num;
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;
    assign w_v[0]    = i_valid;

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DNW:0]   t;
        logic [DNW:0]   diff;
        logic           ge;
        logic [DNW-1:0] r_rem;
        logic [NW-1:0]  r_n;
        logic [DNW-1:0] r_den;
        logic [SBW-1:0] r_side;
        logic           r_v;

        assign t    = {w_rem[k], w_n[k][NW-1]};
        assign ge   = (t >= {1'b0, w_den[k]});
        assign diff = t - {1'b0, w_den[k]};

        always_ff @(posedge i_clk) begin
            r_rem  <= ge ? diff[DNW-1:0] : t[DNW-1:0];
            r_n    <= {w_n[k][NW-2:0], ge};
            r_den  <= w_den[k];
            r_side <= w_side[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= w_v[k];
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_n[k+1]    = r_n;
        assign w_den[k+1]  = r_den;
        assign w_side[k+1] = r_side;
        assign w_v[k+1]    = r_v;
    end

    assign o_valid = w_v[NW];
    assign o_quo   = w_n[NW];
    assign o_side  = w_side[NW];

endmodule

>>> rtl/core/vtpd_back.sv
// Back end: sign handling, three divider lanes, zero-w bypass and saturation.
// Depends on vtpd_pkg and vtpd_div.
module vtpd_back
    import vtpd_pkg::*;
#(
    parameter int DW = 32,
    parameter int AW = 42,
    parameter int QW = AW + 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [NUM_ROWS*AW-1:0] i_acc,
    output logic                   o_valid,
    output logic [PORT_WIDTH-1:0]  o_x,
    output logic [PORT_WIDTH-1:0]  o_y,
    output logic [PORT_WIDTH-1:0]  o_z,
    output logic                   o_w_zero,
    output logic                   o_sat
);

    localparam int SBW = AW + 2;

    logic signed [AW-1:0] w_acc;
    logic signed [AW-1:0] acc [NUM_LANES];
    logic signed [QW-1:0] num [NUM_LANES];
    logic [QW-1:0]        r_num  [NUM_LANES];
    logic [SBW-1:0]       r_side [NUM_LANES];
    logic [AW-1:0]        r_den;
    logic                 r_v0;
    logic                 w_zero;
    logic [AW-1:0]        den_mag;

    logic                 d_valid [NUM_LANES];
    logic [QW-1:0]        d_quo   [NUM_LANES];
    logic [SBW-1:0]       d_side  [NUM_LANES];

    logic signed [QW:0]   val     [NUM_LANES];
    logic signed [QW:0]   quo_s   [NUM_LANES];
    logic [DW-1:0]        clamped [NUM_LANES];
    logic                 lane_sat [NUM_LANES];
    logic [PORT_WIDTH-1:0] n_out  [NUM_LANES];
    logic [PORT_WIDTH-1:0] r_out  [NUM_LANES];
    logic                 r_w_zero;
    logic                 r_sat;
    logic                 r_valid;

    assign w_acc   = $signed(i_acc[NUM_LANES*AW +: AW]);
    assign w_zero  = (w_acc == '0);
    assign den_mag = w_acc[AW-1] ? AW'(-w_acc) : AW'(w_acc);

    always_comb begin
        for (int r = 0; r < NUM_LANES; r++) begin
            acc[r] = $signed(i_acc[r*AW +: AW]);
            num[r] = $signed({acc[r], {FRAC_BITS{1'b0}}});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < NUM_LANES; r++) begin
            r_num[r]  <= num[r][QW-1] ? QW'(-num[r]) : QW'(num[r]);
            r_side[r] <= {acc[r], acc[r][AW-1] ^ w_acc[AW-1], w_zero};
        end
        r_den <= den_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v0    <= i_valid;
            r_valid <= d_valid[0];
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        vtpd_div #(
            .NW  (QW),
            .DNW (AW),
            .SBW (SBW)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_v0),
            .i_num   (r_num[g]),
            .i_den   (r_den),
            .i_side  (r_side[g]),
            .o_valid (d_valid[g]),
            .o_quo   (d_quo[g]),
            .o_side  (d_side[g])
        );
    end

    always_comb begin
        for (int r = 0; r < NUM_LANES; r++) begin
            quo_s[r] = d_side[r][1] ? -$signed({1'b0, d_quo[r]}) : $signed({1'b0, d_quo[r]});
            val[r]   = d_side[r][0] ? (QW+1)'($signed(d_side[r][SBW-1:2])) : quo_s[r];
            lane_sat[r] = (val[r][QW:DW-1] != '0) && (val[r][QW:DW-1] != '1);
            clamped[r]  = lane_sat[r] ? {val[r][QW], {(DW-1){~val[r][QW]}}} : val[r][DW-1:0];
            n_out[r]    = PORT_WIDTH'($signed(clamped[r]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_w_zero <= d_side[0][0];
        r_sat    <= lane_sat[0] | lane_sat[1] | lane_sat[2];
    end

    assign o_valid  = r_valid;
    assign o_x      = r_out[0];
    assign o_y      = r_out[1];
    assign o_z      = r_out[2];
    assign o_w_zero = r_w_zero;
    assign o_sat    = r_sat;

endmodule

>>> rtl/core/vertex_transform_perspective_divide_unit.sv
// Path: front-end product and sum registers, queue, back-end operand registers, the
// one-bit-per-stage divider pipeline and output registers. One point per cycle while
// busy is low; o_valid marks each result for exactly one cycle.
// busy rises only when the front-to-back queue is full; the back end drains every cycle.
// Reset is synchronous and active low: it empties the pipeline and queue and loads
// the identity matrix. Depends on vtpd_pkg, vtpd_front, vtpd_queue, vtpd_back, macros.
`include "vertex_transform_perspective_divide_unit_macros.svh"

module vertex_transform_perspective_divide_unit
    import vtpd_pkg::*;
#(
    parameter int COEF_WIDTH  = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PORT_WIDTH-1:0] i_in_x,
    input  logic [PORT_WIDTH-1:0] i_in_y,
    input  logic [PORT_WIDTH-1:0] i_in_z,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [ROW_WIDTH-1:0]  i_cfg_data,
    output logic                  o_valid,
    output logic [PORT_WIDTH-1:0] o_out_x,
    output logic [PORT_WIDTH-1:0] o_out_y,
    output logic [PORT_WIDTH-1:0] o_out_z,
    output logic                  o_w_was_zero,
    output logic                  o_saturated
);

    localparam int AW = COEF_WIDTH + COORD_WIDTH - 6;
    localparam int QW = AW + FRAC_BITS;

    logic [ROW_WIDTH-1:0]          r_row [NUM_ROWS];
    logic [NUM_ROWS*ROW_WIDTH-1:0] rows_flat;
    logic                          accept;
    logic                          f_valid;
    logic [NUM_ROWS*AW-1:0]        f_acc;
    logic                          q_valid;
    logic [NUM_ROWS*AW-1:0]        q_data;
    t_q_stat                       q_stat;

    assign accept = start && !busy;
    assign busy   = q_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_row[r] <= row_reset(2'(r));
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW0: r_row[0] <= i_cfg_data;
                CFG_ROW1: r_row[1] <= i_cfg_data;
                CFG_ROW2: r_row[2] <= i_cfg_data;
                CFG_ROW3: r_row[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            rows_flat[r*ROW_WIDTH +: ROW_WIDTH] = r_row[r];
        end
    end

    vtpd_front #(
        .CW (COEF_WIDTH),
        .DW (COORD_WIDTH),
        .AW (AW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_x      (i_in_x),
        .i_y      (i_in_y),
        .i_z      (i_in_z),
        .i_rows   (rows_flat),
        .o_valid  (f_valid),
        .o_acc    (f_acc)
    );

    vtpd_queue #(
        .WIDTH (NUM_ROWS*AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_acc),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_stat  (q_stat)
    );

    vtpd_back #(
        .DW (COORD_WIDTH),
        .AW (AW),
        .QW (QW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_acc    (q_data),
        .o_valid  (o_valid),
        .o_x      (o_out_x),
        .o_y      (o_out_y),
        .o_z      (o_out_z),
        .o_w_zero (o_w_was_zero),
        .o_sat    (o_saturated)
    );

    `VTPD_ASSERT_NOW(a_queue_no_overflow, f_valid, !q_stat.full || q_valid, "queue overflow")
    `VTPD_ASSERT_NOW(a_out_x_in_range, o_valid, (o_out_x[PORT_WIDTH-1:COORD_WIDTH-1] == '0) || (o_out_x[PORT_WIDTH-1:COORD_WIDTH-1] == '1), "out_x beyond range")
    `VTPD_ASSERT_NEXT(a_front_reaches_queue, f_valid, !q_stat.empty || q_valid, "front result lost")

endmodule

>>> tb/sv/tb_vertex_transform_perspective_divide_unit.sv
// Self-checking testbench for the vertex transform unit with perspective divide.
// Directed table then random points under many matrices, checked by table or local model.
// Depends on vtpd_pkg and vertex_transform_perspective_divide_unit.
`timescale 1ns / 1ps

module tb_vertex_transform_perspective_divide_unit;
    import vtpd_pkg::*;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        w_zero;
        logic        sat;
    } t_point_res;

    typedef enum int {MTX_IDENT, MTX_ZERO_W, MTX_MAX_COEF, MTX_MIN_COEF} t_mtx_kind;

    typedef struct {
        t_mtx_kind   kind;
        bit          typed;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        w_zero;
        logic        sat;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_in_x = '0;
    logic [31:0] i_in_y = '0;
    logic [31:0] i_in_z = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_ROW0;
    logic [63:0] i_cfg_data = '0;
    logic        o_valid;
    logic [31:0] o_out_x;
    logic [31:0] o_out_y;
    logic [31:0] o_out_z;
    logic        o_w_was_zero;
    logic        o_saturated;

    logic [63:0] matrix[4];
    t_point_res  pending_q[$];
    bit          use_typed = 0;
    t_point_res  typed_res;
    int          mismatches = 0;
    int          points_sent = 0;
    int          results_seen = 0;
    int          idle_pct = 31;

    vertex_transform_perspective_divide_unit dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("vertex_transform_perspective_divide_unit: mismatch");
        $finish;
    end

    function automatic t_point_res transform_point(logic [31:0] x, logic [31:0] y,
                                                   logic [31:0] z);
        longint     vec[4];
        longint     acc[4];
        longint     sum;
        longint     q;
        longint     coef;
        logic [31:0] o[3];
        t_point_res res;
        vec[0] = longint'($signed(x));
        vec[1] = longint'($signed(y));
        vec[2] = longint'($signed(z));
        vec[3] = 65536;
        for (int r = 0; r < 4; r++) begin
            sum = 0;
            for (int j = 0; j < 4; j++) begin
                coef = longint'($signed(matrix[r][16*j +: 16]));
                sum += coef * vec[j];
            end
            acc[r] = sum >>> 8;
        end
        res.sat = 1'b0;
        res.w_zero = (acc[3] == 0);
        for (int i = 0; i < 3; i++) begin
            q = res.w_zero ? acc[i] : (acc[i] * 65536) / acc[3];
            if (q > 64'sd2147483647) begin
                q = 64'sd2147483647;
                res.sat = 1'b1;
            end else if (q < -64'sd2147483648) begin
                q = -64'sd2147483648;
                res.sat = 1'b1;
            end
            o[i] = q[31:0];
        end
        res.x = o[0];
        res.y = o[1];
        res.z = o[2];
        return res;
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 6))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 64)) - 32) << 16;
            3: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 8)) - 4);
            4: return 16'($signed($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Registers are written only with nothing in flight; every point yields a result.
    task automatic load_matrix(logic [63:0] rows[4]);
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        for (int r = 0; r < 4; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(r);
            i_cfg_data <= rows[r];
            @(posedge i_clk);
            matrix[r] = rows[r];
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while (($urandom % 100) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_in_x <= x;
        i_in_y <= y;
        i_in_z <= z;
        do @(posedge i_clk); while (busy);
        points_sent++;
        if (points_sent == 270) idle_pct = 64;
        if (points_sent == 540) idle_pct = 0;
    endtask

    function automatic void kind_rows(t_mtx_kind kind, output logic [63:0] rows[4]);
        rows[0] = 64'h0000_0000_0000_0100;
        rows[1] = 64'h0000_0000_0100_0000;
        rows[2] = 64'h0000_0100_0000_0000;
        rows[3] = 64'h0100_0000_0000_0000;
        case (kind)
            MTX_ZERO_W:   rows[3] = '0;
            MTX_MAX_COEF: for (int r = 0; r < 4; r++) rows[r] = {4{16'h7FFF}};
            MTX_MIN_COEF: for (int r = 0; r < 4; r++) rows[r] = {4{16'h8000}};
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            pending_q.push_back(use_typed ? typed_res : transform_point(i_in_x, i_in_y, i_in_z));
        end
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                report("unexpected result x", o_out_x, '0);
            end else begin
                t_point_res e;
                e = pending_q.pop_front();
                if (o_out_x !== e.x) report("out_x", o_out_x, e.x);
                if (o_out_y !== e.y) report("out_y", o_out_y, e.y);
                if (o_out_z !== e.z) report("out_z", o_out_z, e.z);
                if (o_w_was_zero !== e.w_zero)
                    report("w_was_zero", 32'(o_w_was_zero), 32'(e.w_zero));
                if (o_saturated !== e.sat)
                    report("saturated", 32'(o_saturated), 32'(e.sat));
            end
        end
    end

    initial begin
        t_dir_row    dir_tab[$];
        logic [63:0] rows[4];
        t_mtx_kind   cur_kind;
        dir_tab = '{
            '{MTX_IDENT, 1, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0},
            '{MTX_IDENT, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0, 1'b0},
            '{MTX_IDENT, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0},
            '{MTX_IDENT, 1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b0, 1'b0},
            '{MTX_IDENT, 1, 32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF, 1'b0, 1'b0},
            '{MTX_ZERO_W, 1, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0},
            '{MTX_ZERO_W, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b1, 1'b0},
            '{MTX_ZERO_W, 1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0},
            '{MTX_ZERO_W, 1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 1'b1, 1'b0},
            '{MTX_MAX_COEF, 0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0},
            '{MTX_MAX_COEF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0},
            '{MTX_MAX_COEF, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0},
            '{MTX_MAX_COEF, 0, 32'hFFFF_8000, 32'h0, 32'h0, 1'b0, 1'b0},
            '{MTX_MIN_COEF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, 1'b0},
            '{MTX_MIN_COEF, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0},
            '{MTX_MIN_COEF, 0, 32'hFFFF_0000, 32'h0, 32'h0, 1'b0, 1'b0},
            '{MTX_MIN_COEF, 0, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0}
        };
        kind_rows(MTX_IDENT, rows);
        matrix = rows;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_kind = MTX_IDENT;
        foreach (dir_tab[k]) begin
            if (dir_tab[k].kind != cur_kind) begin
                start <= 1'b0;
                cur_kind = dir_tab[k].kind;
                kind_rows(cur_kind, rows);
                load_matrix(rows);
            end
            use_typed <= dir_tab[k].typed;
            typed_res <= '{dir_tab[k].x, dir_tab[k].y, dir_tab[k].z,
                           dir_tab[k].w_zero, dir_tab[k].sat};
            send_point(dir_tab[k].x, dir_tab[k].y, dir_tab[k].z);
        end
        use_typed <= 0;

        for (int ph = 0; ph < 8; ph++) begin
            start <= 1'b0;
            for (int r = 0; r < 4; r++)
                rows[r] = {pick_coef(), pick_coef(), pick_coef(), pick_coef()};
            // Small w row makes tiny and zero w common.
            if (ph % 3 == 1) rows[3] = {16'h0000, pick_coef() & 16'h0003, 16'h0, 16'h0};
            if (ph == 5) rows[3] = '0;
            load_matrix(rows);
            for (int n = 0; n < 100; n++) send_point(pick_coord(), pick_coord(), pick_coord());
        end
        start <= 1'b0;

        kind_rows(MTX_IDENT, rows);
        load_matrix(rows);
        repeat (70) @(posedge i_clk);
        $display("Sent %0d points through %0d matrix settings, %0d results checked.",
                 points_sent, 12, results_seen);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("vertex_transform_perspective_divide_unit: match");
        end else begin
            $display("vertex_transform_perspective_divide_unit: mismatch");
        end
        $finish;
    end

endmodule
